>>> hw/rtl/lfcs_pkg.sv
// Package for the log frame CRC scanner: shared types, codes and constants.
// Holds the byte-wise CRC-32 update used by the frame scan logic.
// No dependencies.
`default_nettype none

package lfcs_pkg;

    localparam int OFFSET_BITS_DEF = 48;
    localparam int HEADER_BYTES    = 1 + 4 + 4;
    localparam int OUT_OFF_W       = 48;
    localparam int MIN_PAYLOAD     = 2;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] PAYLOAD_CAP_RST = 32'd256 * 32'd1024 * 32'd1024;
    localparam logic [3:0]  BODY_START_RST  = 4'd8;
    localparam logic [7:0]  OP_A_RST        = 8'd1;
    localparam logic [7:0]  OP_B_RST        = 8'd2;
    localparam logic [7:0]  OP_C_RST        = 8'd3;
    localparam logic [7:0]  OP_D_RST        = 8'd4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        V_CLEAN     = 3'd0,
        V_TRUNCATE  = 3'd1,
        V_BAD_OP    = 3'd2,
        V_SHORT     = 3'd3,
        V_OVER_CAP  = 3'd4,
        V_MID_CRC   = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        REG_FORMAT     = 3'd0,
        REG_BODY_START = 3'd1,
        REG_CAP        = 3'd2,
        REG_OP_A       = 3'd3,
        REG_OP_B       = 3'd4,
        REG_OP_C       = 3'd5,
        REG_OP_D       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic        format_current;
        logic [3:0]  body_start;
        logic [31:0] payload_cap;
        logic [7:0]  op_code_a;
        logic [7:0]  op_code_b;
        logic [7:0]  op_code_c;
        logic [7:0]  op_code_d;
    } cfg_t;

    typedef struct packed {
        logic                 result_kind;
        verdict_t             verdict;
        logic [OUT_OFF_W-1:0] frame_offset;
        logic [7:0]           frame_op;
        logic [31:0]          frame_payload_length;
        logic [OUT_OFF_W-1:0] keep_length;
        logic                 last_result;
    } result_t;

    // Up to two results per byte: a good-frame record and then a verdict.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] lane_word(input logic [1:0] lane, input logic [7:0] b);
        return {24'd0, b} << {lane, 3'b000};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/log_frame_crc_scanner_core.sv
// A byte taken is held in the input register and checked there; its results go
// into the result queue. The input stalls while the queue lacks room for two.
// Throughput: else one byte per cycle; the per-byte CRC-32 update and header
// checks sit between the input register and the four-entry result queue.
// A byte that ends a good frame at end of file gives two results, which leave
// over two output transfers. Reset (rst_n low, asynchronous) restores register
// defaults, empties the queue and arms the scan at the body start offset.
`default_nettype none

module log_frame_crc_scanner_core
#(
    parameter int OFFSET_BITS = lfcs_pkg::OFFSET_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_file,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               result_kind,
    output logic [2:0]                         verdict,
    output logic [lfcs_pkg::OUT_OFF_W-1:0]     frame_offset,
    output logic [7:0]                         frame_op,
    output logic [31:0]                        frame_payload_length,
    output logic [lfcs_pkg::OUT_OFF_W-1:0]     keep_length,
    output logic                               last_result
);

    lfcs_pkg::cfg_t    cfg;
    logic              bs_wr;
    logic [3:0]        bs_val;
    lfcs_pkg::push_t   push;
    logic              room;
    lfcs_pkg::result_t head;

    lfcs_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .bs_wr     (bs_wr),
        .bs_val    (bs_val)
    );

    lfcs_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .room        (room),
        .cfg         (cfg),
        .bs_wr       (bs_wr),
        .bs_val      (bs_val),
        .push        (push)
    );

    lfcs_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign result_kind          = head.result_kind;
    assign verdict              = head.verdict;
    assign frame_offset         = head.frame_offset;
    assign frame_op             = head.frame_op;
    assign frame_payload_length = head.frame_payload_length;
    assign keep_length          = head.keep_length;
    assign last_result          = head.last_result;

endmodule

`default_nettype wire

>>> hw/rtl/lfcs_cfg_regs.sv
// Configuration register bank of the log frame CRC scanner.
// Depends on lfcs_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module lfcs_cfg_regs
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    output lfcs_pkg::cfg_t          cfg,
    output logic                    bs_wr,
    output logic [3:0]              bs_val
);

    lfcs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_current <= 1'b1;
            cfg_reg.body_start     <= lfcs_pkg::BODY_START_RST;
            cfg_reg.payload_cap    <= lfcs_pkg::PAYLOAD_CAP_RST;
            cfg_reg.op_code_a      <= lfcs_pkg::OP_A_RST;
            cfg_reg.op_code_b      <= lfcs_pkg::OP_B_RST;
            cfg_reg.op_code_c      <= lfcs_pkg::OP_C_RST;
            cfg_reg.op_code_d      <= lfcs_pkg::OP_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfcs_pkg::REG_FORMAT:     cfg_reg.format_current <= cfg_wdata[0];
                lfcs_pkg::REG_BODY_START: cfg_reg.body_start     <= cfg_wdata[3:0];
                lfcs_pkg::REG_CAP:        cfg_reg.payload_cap    <= cfg_wdata;
                lfcs_pkg::REG_OP_A:       cfg_reg.op_code_a      <= cfg_wdata[7:0];
                lfcs_pkg::REG_OP_B:       cfg_reg.op_code_b      <= cfg_wdata[7:0];
                lfcs_pkg::REG_OP_C:       cfg_reg.op_code_c      <= cfg_wdata[7:0];
                lfcs_pkg::REG_OP_D:       cfg_reg.op_code_d      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg    = cfg_reg;
    // The scan logic re-arms on a body start write while no byte of the file was taken.
    assign bs_wr  = cfg_we && (cfg_index == lfcs_pkg::REG_BODY_START);
    assign bs_val = cfg_wdata[3:0];

endmodule

`default_nettype wire

>>> hw/rtl/lfcs_scan.sv
// Frame scan stage: input register, frame state and the per-byte check logic.
// Depends on lfcs_pkg for types, codes and the CRC-32 byte update.
`default_nettype none

module lfcs_scan
#(
    parameter int OFFSET_BITS = lfcs_pkg::OFFSET_BITS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     data_byte,
    input  wire logic           end_of_file,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           room,
    input  wire lfcs_pkg::cfg_t cfg,
    input  wire logic           bs_wr,
    input  wire logic [3:0]     bs_val,
    output lfcs_pkg::push_t     push
);

    localparam logic [3:0] HDR_LAST = 4'(lfcs_pkg::HEADER_BYTES - 1);

    logic                   in_vld_reg, in_vld_next;
    logic [7:0]             in_byte_reg;
    logic                   in_eof_reg;

    lfcs_pkg::phase_t       phase_reg, phase_next;
    logic [3:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]             held_op_reg, held_op_next;
    logic [31:0]            stored_crc_reg, stored_crc_next;
    logic [31:0]            pay_len_reg, pay_len_next;
    logic [31:0]            pay_left_reg, pay_left_next;
    logic [31:0]            crc_reg, crc_next;
    logic [OFFSET_BITS-1:0] cursor_reg, cursor_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] good_end_reg, good_end_next;
    logic                   started_reg, started_next;

    logic                   step;
    logic                   accept;
    logic [31:0]            crc_src;
    logic [31:0]            crc_new;
    logic                   op_ok;
    logic [31:0]            left_dec;
    logic                   v_hit;
    logic                   rec_hit;
    lfcs_pkg::verdict_t     v_code;
    logic                   rearm;
    logic [OFFSET_BITS-1:0] rearm_off;
    logic [63:0]            begin_wide;
    logic [63:0]            good_wide;
    lfcs_pkg::result_t      rec;
    lfcs_pkg::result_t      ver;

    // A held byte is worked on once the result queue can take two entries.
    assign step     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_eof_reg  <= end_of_file;
        end
    end

    // The first header byte restarts the checksum.
    assign crc_src = (phase_reg == lfcs_pkg::PH_HEADER && hdr_cnt_reg == 4'd0)
                     ? lfcs_pkg::CRC_INIT : crc_reg;
    assign crc_new = lfcs_pkg::crc_byte(crc_src, in_byte_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        held_op_next    = held_op_reg;
        stored_crc_next = stored_crc_reg;
        pay_len_next    = pay_len_reg;
        pay_left_next   = pay_left_reg;
        crc_next        = crc_reg;
        cursor_next     = cursor_reg;
        begin_next      = begin_reg;
        good_end_next   = good_end_reg;
        started_next    = started_reg;
        v_hit           = 1'b0;
        rec_hit         = 1'b0;
        v_code          = lfcs_pkg::V_CLEAN;
        op_ok           = 1'b0;
        left_dec        = pay_left_reg;

        if (step)
        begin
            case (phase_reg)
                lfcs_pkg::PH_HEADER:
                begin
                    if (hdr_cnt_reg == 4'd0)
                    begin
                        begin_next      = cursor_reg;
                        stored_crc_next = 32'd0;
                        pay_len_next    = 32'd0;
                        held_op_next    = in_byte_reg;
                        crc_next        = crc_new;
                    end
                    else if (hdr_cnt_reg <= 4'd4)
                    begin
                        stored_crc_next = cfg.format_current
                            ? {stored_crc_reg[23:0], in_byte_reg}
                            : stored_crc_reg
                              | lfcs_pkg::lane_word(2'(hdr_cnt_reg - 4'd1), in_byte_reg);
                    end
                    else
                    begin
                        pay_len_next = cfg.format_current
                            ? {pay_len_reg[23:0], in_byte_reg}
                            : pay_len_reg
                              | lfcs_pkg::lane_word(2'(hdr_cnt_reg - 4'd5), in_byte_reg);
                        crc_next = crc_new;
                    end

                    op_ok = held_op_next == cfg.op_code_a || held_op_next == cfg.op_code_b
                         || held_op_next == cfg.op_code_c || held_op_next == cfg.op_code_d;

                    if (hdr_cnt_reg == HDR_LAST)
                    begin
                        hdr_cnt_next = 4'd0;
                        if (!op_ok)
                        begin
                            v_hit  = 1'b1;
                            v_code = cfg.format_current ? lfcs_pkg::V_BAD_OP
                                                        : lfcs_pkg::V_TRUNCATE;
                        end
                        else if (pay_len_next < 32'(lfcs_pkg::MIN_PAYLOAD))
                        begin
                            v_hit  = 1'b1;
                            v_code = cfg.format_current ? lfcs_pkg::V_SHORT
                                                        : lfcs_pkg::V_TRUNCATE;
                        end
                        else if (pay_len_next > cfg.payload_cap)
                        begin
                            v_hit  = 1'b1;
                            v_code = lfcs_pkg::V_OVER_CAP;
                        end
                        else if (in_eof_reg)
                        begin
                            v_hit  = 1'b1;
                            v_code = lfcs_pkg::V_TRUNCATE;
                        end
                        else
                        begin
                            phase_next    = lfcs_pkg::PH_PAYLOAD;
                            pay_left_next = pay_len_next;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        if (in_eof_reg)
                        begin
                            v_hit  = 1'b1;
                            v_code = lfcs_pkg::V_TRUNCATE;
                        end
                    end
                end
                lfcs_pkg::PH_PAYLOAD:
                begin
                    crc_next      = crc_new;
                    left_dec      = (pay_left_reg != 32'd0) ? pay_left_reg - 32'd1
                                                            : pay_left_reg;
                    pay_left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        if (~crc_new == stored_crc_reg)
                        begin
                            good_end_next = cursor_reg + OFFSET_BITS'(1);
                            rec_hit       = 1'b1;
                            phase_next    = lfcs_pkg::PH_HEADER;
                            hdr_cnt_next  = 4'd0;
                            if (in_eof_reg)
                            begin
                                v_hit  = 1'b1;
                                v_code = lfcs_pkg::V_CLEAN;
                            end
                        end
                        else
                        begin
                            v_hit  = 1'b1;
                            v_code = in_eof_reg ? lfcs_pkg::V_TRUNCATE
                                                : lfcs_pkg::V_MID_CRC;
                        end
                    end
                    else if (in_eof_reg)
                    begin
                        v_hit  = 1'b1;
                        v_code = lfcs_pkg::V_TRUNCATE;
                    end
                end
                default: ;
            endcase

            cursor_next  = cursor_reg + OFFSET_BITS'(1);
            started_next = 1'b1;
            if (v_hit)
            begin
                phase_next = lfcs_pkg::PH_DONE;
            end
        end

        // Offsets leave the block on 48-bit fields whatever the internal width.
        begin_wide = 64'(begin_next);
        good_wide  = 64'(good_end_next);

        rec.result_kind          = 1'b0;
        rec.verdict              = lfcs_pkg::V_CLEAN;
        rec.frame_offset         = begin_wide[lfcs_pkg::OUT_OFF_W-1:0];
        rec.frame_op             = held_op_reg;
        rec.frame_payload_length = pay_len_reg;
        rec.keep_length          = good_wide[lfcs_pkg::OUT_OFF_W-1:0];
        rec.last_result          = !v_hit;

        ver.result_kind          = 1'b1;
        ver.verdict              = v_code;
        ver.frame_offset         = (v_code == lfcs_pkg::V_CLEAN)
                                   ? good_wide[lfcs_pkg::OUT_OFF_W-1:0]
                                   : begin_wide[lfcs_pkg::OUT_OFF_W-1:0];
        ver.frame_op             = 8'd0;
        ver.frame_payload_length = 32'd0;
        ver.keep_length          = good_wide[lfcs_pkg::OUT_OFF_W-1:0];
        ver.last_result          = 1'b1;

        push.v0 = rec_hit || v_hit;
        push.v1 = rec_hit && v_hit;
        push.r0 = rec_hit ? rec : ver;
        push.r1 = ver;

        // End of file re-arms for the next file; so does a body start write
        // before the first byte of a file.
        rearm     = (step && in_eof_reg) || (!step && bs_wr && !started_reg);
        rearm_off = step ? OFFSET_BITS'(cfg.body_start) : OFFSET_BITS'(bs_val);
        if (rearm)
        begin
            phase_next      = lfcs_pkg::PH_HEADER;
            hdr_cnt_next    = 4'd0;
            held_op_next    = 8'd0;
            stored_crc_next = 32'd0;
            pay_len_next    = 32'd0;
            pay_left_next   = 32'd0;
            crc_next        = lfcs_pkg::CRC_INIT;
            cursor_next     = rearm_off;
            begin_next      = rearm_off;
            good_end_next   = rearm_off;
            started_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lfcs_pkg::PH_HEADER;
            hdr_cnt_reg    <= 4'd0;
            held_op_reg    <= 8'd0;
            stored_crc_reg <= 32'd0;
            pay_len_reg    <= 32'd0;
            pay_left_reg   <= 32'd0;
            crc_reg        <= lfcs_pkg::CRC_INIT;
            cursor_reg     <= OFFSET_BITS'(lfcs_pkg::BODY_START_RST);
            begin_reg      <= OFFSET_BITS'(lfcs_pkg::BODY_START_RST);
            good_end_reg   <= OFFSET_BITS'(lfcs_pkg::BODY_START_RST);
            started_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            held_op_reg    <= held_op_next;
            stored_crc_reg <= stored_crc_next;
            pay_len_reg    <= pay_len_next;
            pay_left_reg   <= pay_left_next;
            crc_reg        <= crc_next;
            cursor_reg     <= cursor_next;
            begin_reg      <= begin_next;
            good_end_reg   <= good_end_next;
            started_reg    <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lfcs_out_fifo.sv
// Result queue of the log frame CRC scanner: takes up to two results per
// cycle and hands out one per output transfer. Depends on lfcs_pkg.
`default_nettype none

module lfcs_out_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lfcs_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output lfcs_pkg::result_t    head
);

    localparam int DEPTH = lfcs_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    lfcs_pkg::result_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [CW-1:0] n_push;

    assign out_valid = count_reg != CW'(0);
    assign head      = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // Room for the worst case of two results from one byte.
    assign room      = count_reg <= CW'(DEPTH - 2);
    assign n_push    = CW'(push.v0) + CW'(push.v1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + PW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lfcs_checker.sv
// Port-level checks for the log frame CRC scanner, bound to the top level.
// Depends on lfcs_pkg for the verdict codes.
`default_nettype none

module lfcs_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          result_kind,
    input wire logic [2:0]                    verdict,
    input wire logic [7:0]                    frame_op,
    input wire logic [31:0]                   frame_payload_length,
    input wire logic                          last_result
);

    // A result waiting on a stalled output stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer dropped while stalled");

    // A good-frame record always carries a clean code and a legal length.
    a_record_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |->
            verdict == lfcs_pkg::V_CLEAN && frame_payload_length >= 32'd2)
        else $error("good-frame record with bad verdict or length");

    // A verdict carries no op or length and uses a defined code.
    a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |->
            frame_op == 8'd0 && frame_payload_length == 32'd0
            && verdict <= lfcs_pkg::V_MID_CRC)
        else $error("verdict with stray fields or unknown code");

    // A verdict is always the final result of its byte.
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> last_result)
        else $error("verdict not marked as last result");

endmodule

bind log_frame_crc_scanner_core lfcs_checker u_lfcs_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .result_kind          (result_kind),
    .verdict              (verdict),
    .frame_op             (frame_op),
    .frame_payload_length (frame_payload_length),
    .last_result          (last_result)
);

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for log_frame_crc_scanner_core: builds log files of CRC-framed records,
// streams them through the block with random idling on both sides and checks every result.
// Depends on lfcs_pkg and the scanner RTL; needs nothing else.

import lfcs_pkg::*;

class frame_check_board;
    bit                 fmt_cur;
    bit [3:0]           body_start;
    bit [31:0]          cap;
    bit [7:0]           ops[4];

    phase_t             phase;
    int unsigned        hdr_cnt;
    bit [7:0]           op_held;
    bit [31:0]          crc_want;
    bit [31:0]          plen;
    bit [31:0]          pleft;
    bit [31:0]          crc_acc;
    bit [OUT_OFF_W-1:0] cursor;
    bit [OUT_OFF_W-1:0] frame_start;
    bit [OUT_OFF_W-1:0] keep_end;
    bit                 begun;

    result_t            results_due[$];
    int                 mismatches;

    function new();
        fmt_cur = 1'b1;
        body_start = BODY_START_RST;
        cap = PAYLOAD_CAP_RST;
        ops[0] = OP_A_RST;
        ops[1] = OP_B_RST;
        ops[2] = OP_C_RST;
        ops[3] = OP_D_RST;
        mismatches = 0;
        restart();
    endfunction

    static function bit [31:0] crc_upd(bit [31:0] c, bit [7:0] b);
        bit fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function bit op_ok(bit [7:0] op);
        return op == ops[0] || op == ops[1] || op == ops[2] || op == ops[3];
    endfunction

    function void restart();
        phase = PH_HEADER;
        hdr_cnt = 0;
        op_held = '0;
        crc_want = '0;
        plen = '0;
        pleft = '0;
        crc_acc = CRC_INIT;
        cursor = OUT_OFF_W'(body_start);
        frame_start = cursor;
        keep_end = cursor;
        begun = 1'b0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
        case (idx)
            REG_FORMAT:
                fmt_cur = val[0];
            REG_BODY_START:
            begin
                body_start = val[3:0];
                // A new start offset applies at once before the first byte of a file, else once the file is over.
                if (!begun)
                    restart();
            end
            REG_CAP:  cap = val;
            REG_OP_A: ops[0] = val[7:0];
            REG_OP_B: ops[1] = val[7:0];
            REG_OP_C: ops[2] = val[7:0];
            REG_OP_D: ops[3] = val[7:0];
            default: ;
        endcase
    endfunction

    function void scan_byte(bit [7:0] b, bit eof);
        bit          cur;
        bit          has_rec;
        bit          has_fin;
        verdict_t    v;
        result_t     rec;
        result_t     fin;
        int unsigned idx;
        cur = fmt_cur;
        has_rec = 1'b0;
        has_fin = 1'b0;
        v = V_CLEAN;
        rec = '0;
        fin = '0;
        begun = 1'b1;
        if (phase == PH_DONE)
        begin
            if (eof)
                restart();
            return;
        end
        if (phase == PH_HEADER)
        begin
            idx = hdr_cnt;
            if (idx == 0)
            begin
                frame_start = cursor;
                crc_want = '0;
                plen = '0;
                op_held = b;
                crc_acc = crc_upd(CRC_INIT, b);
            end
            else if (idx <= 4)
            begin
                if (cur)
                    crc_want = {crc_want[23:0], b};
                else
                    crc_want = crc_want | (32'(b) << (8 * (idx - 1)));
            end
            else
            begin
                if (cur)
                    plen = {plen[23:0], b};
                else
                    plen = plen | (32'(b) << (8 * ((idx - 5) & 3)));
                crc_acc = crc_upd(crc_acc, b);
            end
            hdr_cnt = idx + 1;
            if (hdr_cnt >= HEADER_BYTES)
            begin
                // Header checks on a complete header win over a truncated file.
                hdr_cnt = 0;
                has_fin = 1'b1;
                if (!op_ok(op_held))
                    v = cur ? V_BAD_OP : V_TRUNCATE;
                else if (plen < MIN_PAYLOAD)
                    v = cur ? V_SHORT : V_TRUNCATE;
                else if (plen > cap)
                    v = V_OVER_CAP;
                else if (eof)
                    v = V_TRUNCATE;
                else
                begin
                    has_fin = 1'b0;
                    phase = PH_PAYLOAD;
                    pleft = plen;
                end
            end
            else if (eof)
            begin
                has_fin = 1'b1;
                v = V_TRUNCATE;
            end
        end
        else
        begin
            crc_acc = crc_upd(crc_acc, b);
            if (pleft != 0)
                pleft = pleft - 1;
            if (pleft == 0)
            begin
                if (~crc_acc == crc_want)
                begin
                    keep_end = cursor + 1;
                    has_rec = 1'b1;
                    rec.result_kind = 1'b0;
                    rec.verdict = V_CLEAN;
                    rec.frame_offset = frame_start;
                    rec.frame_op = op_held;
                    rec.frame_payload_length = plen;
                    rec.keep_length = keep_end;
                    phase = PH_HEADER;
                    hdr_cnt = 0;
                    if (eof)
                    begin
                        has_fin = 1'b1;
                        v = V_CLEAN;
                    end
                end
                else
                begin
                    has_fin = 1'b1;
                    v = eof ? V_TRUNCATE : V_MID_CRC;
                end
            end
            else if (eof)
            begin
                has_fin = 1'b1;
                v = V_TRUNCATE;
            end
        end
        cursor = cursor + 1;
        if (has_fin)
        begin
            fin.result_kind = 1'b1;
            fin.verdict = v;
            fin.frame_offset = (v == V_CLEAN) ? keep_end : frame_start;
            fin.keep_length = keep_end;
            fin.last_result = 1'b1;
            phase = PH_DONE;
        end
        else if (has_rec)
        begin
            rec.last_result = 1'b1;
        end
        if (has_rec)
            results_due = {results_due, rec};
        if (has_fin)
            results_due = {results_due, fin};
        if (eof)
            restart();
    endfunction

    task report(string msg);
        mismatches++;
        $display("[tb] %s", msg);
    endtask

    task match_result(result_t got);
        result_t want;
        string   diffs;
        if (results_due.size() == 0)
        begin
            report($sformatf("unexpected result: kind %0d verdict %0d offset %0d",
                             got.result_kind, got.verdict, got.frame_offset));
            return;
        end
        want = results_due.pop_front();
        diffs = "";
        if (got.result_kind !== want.result_kind)
            diffs = {diffs, $sformatf(" result_kind %0d/%0d", got.result_kind,
                                      want.result_kind)};
        if (got.verdict !== want.verdict)
            diffs = {diffs, $sformatf(" verdict %0d/%0d", got.verdict, want.verdict)};
        if (got.frame_offset !== want.frame_offset)
            diffs = {diffs, $sformatf(" frame_offset %0d/%0d", got.frame_offset,
                                      want.frame_offset)};
        if (got.frame_op !== want.frame_op)
            diffs = {diffs, $sformatf(" frame_op %0d/%0d", got.frame_op, want.frame_op)};
        if (got.frame_payload_length !== want.frame_payload_length)
            diffs = {diffs, $sformatf(" frame_payload_length %0d/%0d",
                                      got.frame_payload_length, want.frame_payload_length)};
        if (got.keep_length !== want.keep_length)
            diffs = {diffs, $sformatf(" keep_length %0d/%0d", got.keep_length,
                                      want.keep_length)};
        if (got.last_result !== want.last_result)
            diffs = {diffs, $sformatf(" last_result %0d/%0d", got.last_result,
                                      want.last_result)};
        if (diffs != "")
            report({"result mismatch (got/want):", diffs});
    endtask

    function int pending();
        return results_due.size();
    endfunction
endclass

module tb_top;
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 180;
    localparam int         NUM_PHASES    = 6;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [2:0]           cfg_index   = '0;
    logic [31:0]          cfg_wdata   = '0;
    logic                 in_valid    = 1'b0;
    logic [7:0]           data_byte   = '0;
    logic                 end_of_file = 1'b0;
    logic                 out_stall   = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 result_kind;
    logic [2:0]           verdict;
    logic [OUT_OFF_W-1:0] frame_offset;
    logic [7:0]           frame_op;
    logic [31:0]          frame_payload_length;
    logic [OUT_OFF_W-1:0] keep_length;
    logic                 last_result;

    frame_check_board     board;
    result_t              got;
    bit [8:0]             file_q[$];
    int unsigned          items_sent  = 0;
    bit                   quiet       = 1'b0;
    bit                   idle_on     = 1'b0;
    int unsigned          idle_cycles = 0;
    int unsigned          stall_left  = 0;
    int unsigned          calm_left   = 20;

    log_frame_crc_scanner_core u_top
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .data_byte            (data_byte),
        .end_of_file          (end_of_file),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .result_kind          (result_kind),
        .verdict              (verdict),
        .frame_offset         (frame_offset),
        .frame_op             (frame_op),
        .frame_payload_length (frame_payload_length),
        .keep_length          (keep_length),
        .last_result          (last_result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Both sides of every transfer are sampled here, before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.scan_byte(data_byte, end_of_file);
        if (rst_n && out_valid && !out_stall)
        begin
            got.result_kind = result_kind;
            got.verdict = verdict_t'(verdict);
            got.frame_offset = frame_offset;
            got.frame_op = frame_op;
            got.frame_payload_length = frame_payload_length;
            got.keep_length = keep_length;
            got.last_result = last_result;
            board.match_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Random stall bursts on the output, separated by calm stretches of varying length.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (calm_left != 0)
        begin
            out_stall <= 1'b0;
            calm_left <= calm_left - 1;
        end
        else
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
            calm_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 20);
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("[log_frame_crc_scanner_core] ERROR");
        $finish;
    end

    task automatic send_byte(bit [7:0] b, bit eof);
        if (!quiet && idle_on && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Holds the sender until every expected result is out and the pipeline is empty.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(bit [2:0] idx, bit [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic apply_settings(bit fmt, bit [3:0] bs, bit [31:0] cp,
                                  bit [7:0] a, bit [7:0] b, bit [7:0] c, bit [7:0] d);
        cfg_write(REG_FORMAT, 32'(fmt));
        cfg_write(REG_BODY_START, 32'(bs));
        cfg_write(REG_CAP, cp);
        cfg_write(REG_OP_A, 32'(a));
        cfg_write(REG_OP_B, 32'(b));
        cfg_write(REG_OP_C, 32'(c));
        cfg_write(REG_OP_D, 32'(d));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Queues one frame in the current byte order. pay_n payload bytes follow the
    // header; cut, when not negative, keeps only that many bytes of the frame.
    function automatic void add_frame(bit [7:0] op, bit [31:0] len, int unsigned pay_n,
                                      bit spoil, int cut);
        bit [7:0]  fr[$];
        bit [7:0]  pay[$];
        bit [7:0]  lb[4];
        bit [7:0]  cb[4];
        bit [7:0]  p;
        bit [31:0] c;
        int        keep;
        for (int i = 0; i < 4; i++)
        begin
            lb[i] = board.fmt_cur ? len[8 * (3 - i) +: 8] : len[8 * i +: 8];
        end
        c = board.crc_upd(CRC_INIT, op);
        for (int i = 0; i < 4; i++)
        begin
            c = board.crc_upd(c, lb[i]);
        end
        for (int i = 0; i < pay_n; i++)
        begin
            p = $urandom_range(0, 255);
            pay = {pay, p};
            c = board.crc_upd(c, p);
        end
        c = ~c;
        if (spoil)
            c = c ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
        begin
            cb[i] = board.fmt_cur ? c[8 * (3 - i) +: 8] : c[8 * i +: 8];
        end
        fr = {fr, op};
        for (int i = 0; i < 4; i++)
        begin
            fr = {fr, cb[i]};
        end
        for (int i = 0; i < 4; i++)
        begin
            fr = {fr, lb[i]};
        end
        foreach (pay[i])
        begin
            fr = {fr, pay[i]};
        end
        keep = (cut < 0) ? fr.size() : cut;
        for (int i = 0; i < keep; i++)
        begin
            file_q = {file_q, {1'b0, fr[i]}};
        end
        items_sent += keep;
    endfunction

    // Trailing bytes after a verdict; the block drops them until end of file.
    function automatic void add_junk(int n);
        for (int i = 0; i < n; i++)
        begin
            file_q = {file_q, {1'b0, 8'($urandom_range(0, 255))}};
        end
    endfunction

    function automatic bit [7:0] pick_op();
        return board.ops[$urandom_range(0, 3)];
    endfunction

    function automatic bit [7:0] bad_op();
        bit [7:0] op;
        do
            op = $urandom_range(0, 255);
        while (board.op_ok(op));
        return op;
    endfunction

    function automatic bit [31:0] pick_len();
        bit [31:0] hi;
        hi = ($urandom_range(0, 24) == 0) ? 32'd300 : 32'd16;
        if (board.cap < hi)
            hi = board.cap;
        return $urandom_range(hi, MIN_PAYLOAD);
    endfunction

    task automatic send_file();
        bit [8:0] e;
        if (file_q.size() == 0)
            return;
        e = file_q.pop_back();
        e[8] = 1'b1;
        file_q = {file_q, e};
        idle_on = ($urandom_range(0, 3) != 0);
        while (file_q.size() != 0)
        begin
            e = file_q.pop_front();
            send_byte(e[7:0], e[8]);
            if (!quiet && $urandom_range(0, 149) == 0)
                wait_drain();
        end
    endtask

    task automatic run_random_file();
        int        nfr;
        int        ending;
        bit [31:0] len;
        nfr = $urandom_range(0, 4);
        ending = $urandom_range(0, 11);
        if (nfr == 0 && ending < 5)
            nfr = 1;
        repeat (nfr)
        begin
            len = pick_len();
            add_frame(pick_op(), len, len, 1'b0, -1);
        end
        len = pick_len();
        case (ending)
            5:  add_frame(pick_op(), len, len, 1'b1, -1);
            6:
            begin
                add_frame(pick_op(), len, len, 1'b1, -1);
                add_junk($urandom_range(1, 6));
            end
            7:
            begin
                add_frame(bad_op(), len, 0, 1'b0, -1);
                add_junk($urandom_range(0, 4));
            end
            8:
            begin
                add_frame(pick_op(), 32'($urandom_range(0, 1)), 0, 1'b0, -1);
                add_junk($urandom_range(0, 4));
            end
            9:
            begin
                if (board.cap == 32'hFFFF_FFFF)
                    len = 32'($urandom_range(0, 1));
                else
                    len = $urandom_range(0, 1) ? board.cap + 1 : 32'hFFFF_FFFF;
                add_frame(pick_op(), len, 0, 1'b0, -1);
                add_junk($urandom_range(0, 4));
            end
            10: add_frame(pick_op(), len, len, 1'b0, $urandom_range(1, HEADER_BYTES));
            11: add_frame(pick_op(), len, len, 1'b0,
                          HEADER_BYTES + $urandom_range(1, len - 1));
            default: ;
        endcase
        send_file();
    endtask

    // Changes the byte order and the start offset in the middle of a frame header.
    task automatic split_file_test();
        bit [8:0] e;
        add_frame(pick_op(), 32'd6, 6, 1'b0, -1);
        repeat (5)
        begin
            e = file_q.pop_front();
            send_byte(e[7:0], 1'b0);
        end
        wait_drain();
        cfg_write(REG_FORMAT, 32'(!board.fmt_cur));
        cfg_write(REG_BODY_START, 32'd3);
        cfg_write(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        send_file();
        wait_drain();
    endtask

    initial
    begin
        int unsigned goal;
        bit [31:0]   rcap;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Good minimal frame ending the file, a bad header at end of file, a cut header.
        add_frame(OP_A_RST, MIN_PAYLOAD, MIN_PAYLOAD, 1'b0, -1);
        send_file();
        add_frame(8'hFF, 32'hFFFF_FFFF, 0, 1'b0, -1);
        send_file();
        add_frame(OP_B_RST, 32'd5, 5, 1'b0, 3);
        send_file();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drain();
            if (ph == 3)
                split_file_test();
            quiet = (ph == NUM_PHASES - 1);
            case (ph)
                0: apply_settings(1'b0, 4'd0, 32'hFFFF_FFFF, 8'd0, 8'd255, 8'd7, 8'd128);
                1: apply_settings(1'b1, 4'd5, 32'd2, 8'd255, 8'd254, 8'd0, 8'd1);
                2: apply_settings(1'b0, BODY_START_RST, 32'd9,
                                  OP_A_RST, OP_B_RST, OP_C_RST, OP_D_RST);
                3: apply_settings(1'b1, 4'd3, PAYLOAD_CAP_RST,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                4:
                begin
                    rcap = $urandom_range(0, 1) ? 32'($urandom_range(2, 40)) : $urandom;
                    if (rcap < MIN_PAYLOAD)
                        rcap = MIN_PAYLOAD;
                    apply_settings(1'($urandom_range(0, 1)), 4'($urandom_range(0, 8)), rcap,
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                default: apply_settings(1'b1, BODY_START_RST, PAYLOAD_CAP_RST,
                                        OP_A_RST, OP_B_RST, OP_C_RST, OP_D_RST);
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                run_random_file();
        end
        wait_drain();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("[log_frame_crc_scanner_core] OK");
        else
            $display("[log_frame_crc_scanner_core] ERROR");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/lfcs_pkg.sv
hw/rtl/lfcs_cfg_regs.sv
hw/rtl/lfcs_scan.sv
hw/rtl/lfcs_out_fifo.sv
hw/rtl/log_frame_crc_scanner_core.sv
hw/rtl/lfcs_checker.sv
tb/tb_top.sv
